@@ sv/bfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, operation codes and the byte priority encoder for the bitmap finder.
// No dependencies; imported by bfs_ctrl and bitmap_find_next_set_unit.
package bfs_pkg;

  localparam int SIZE_W  = 13;   // size register and found index width
  localparam int START_W = 12;   // start index width
  localparam int BADDR_W = 9;    // byte address width
  localparam int BYTE_W  = 8;    // bits per stored word
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  // Operation codes carried on in_func; the fourth code is a no-op.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_FIRST = 2'd1,
    FUNC_NEXT  = 2'd2
  } func_t;

  // Configuration register indexes.
  localparam logic REG_SIZE = 1'b0;

  typedef struct packed {
    logic              found;
    logic [SIZE_W-1:0] index;
  } result_t;

  // Position of the lowest set bit of a byte (zero for an empty byte).
  function automatic logic [2:0] lowest_bit(input logic [BYTE_W-1:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (b[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ sv/bfs_store.sv @@
`timescale 1ns / 1ps
// Byte-wide bitmap memory: one write port, one read port, registered read data.
// Standalone; instantiated by bitmap_find_next_set_unit.
module bfs_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bfs_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the bitmap finder: clearing pass, byte writes and byte-per-cycle scans.
// Depends on bfs_pkg; drives the ports of bfs_store.
module bfs_ctrl
  import bfs_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         func,
  input  logic [BADDR_W-1:0] byte_address,
  input  logic [BYTE_W-1:0]  byte_data,
  input  logic [START_W-1:0] start_index,
  input  logic [SIZE_W-1:0]  size_eff,
  output logic               busy,
  output logic               res_valid,
  output result_t            res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [BYTE_W-1:0]  mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [BYTE_W-1:0]  mem_rdata
);

  // Bit-index width: holds any byte start address plus one byte of headroom.
  localparam int CW = (AW + 4 > SIZE_W + 1) ? AW + 4 : SIZE_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]     base_r, base_nxt;
  logic [BYTE_W-1:0] mask_r, mask_nxt;
  logic              res_valid_r, res_valid_nxt;
  result_t           res_r, res_nxt;

  logic [SIZE_W-1:0] from;
  logic [CW-1:0]     from_ext;
  logic [CW-1:0]     size_ext;
  logic [CW-1:0]     next_base;
  logic [CW-1:0]     hit_pos;
  logic [BYTE_W-1:0] cur;
  logic              addr_ok;

  assign size_ext  = CW'(size_eff);
  assign next_base = base_r + CW'(BYTE_W);
  assign cur       = mem_rdata & mask_r;
  assign hit_pos   = base_r | CW'(lowest_bit(cur));
  assign addr_ok   = 32'(byte_address) < 32'(DEPTH);

  always_comb begin
    if (func == FUNC_NEXT) begin
      from = SIZE_W'(start_index) + SIZE_W'(1);
    end else begin
      from = '0;
    end
  end

  assign from_ext = CW'(from);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    base_nxt      = base_r;
    mask_nxt      = mask_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(byte_address);
    mem_wdata     = byte_data;
    mem_raddr     = from_ext[AW+2:3];

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (32'(clr_cnt_r) == DEPTH - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (func)
            FUNC_WRITE: begin
              mem_we        = addr_ok;
              res_valid_nxt = 1'b1;
              res_nxt       = '{found: 1'b0, index: '0};
            end
            FUNC_FIRST, FUNC_NEXT: begin
              if (from >= size_eff) begin
                res_valid_nxt = 1'b1;
                res_nxt       = '{found: 1'b0, index: size_eff};
              end else begin
                base_nxt  = {from_ext[CW-1:3], 3'b000};
                mask_nxt  = BYTE_ONES << from[2:0];
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              res_valid_nxt = 1'b1;
              res_nxt       = '{found: 1'b0, index: '0};
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_raddr = next_base[AW+2:3];
        if (cur != '0) begin
          // Hit in this byte; drop it if it lies in the unused tail.
          res_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (hit_pos >= size_ext) begin
            res_nxt = '{found: 1'b0, index: size_eff};
          end else begin
            res_nxt = '{found: 1'b1, index: hit_pos[SIZE_W-1:0]};
          end
        end else if (next_base >= size_ext) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{found: 1'b0, index: size_eff};
          state_nxt     = ST_IDLE;
        end else begin
          base_nxt = next_base;
          mask_nxt = BYTE_ONES;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    mask_r <= mask_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ sv/bitmap_find_next_set_unit.sv @@
`timescale 1ns / 1ps
// Top level of the bitmap finder: APB size register, sequencer and bitmap memory.
// Depends on bfs_pkg, bfs_store and bfs_ctrl.
//
// Usage:
//   Command channel: present in_func and its operands with start high; the word is
//   taken at the rising edge where start is high and busy is low. in_func selects
//   write byte (in_byte_address, in_byte_data), find first set bit, or find next
//   set bit strictly above in_start_index. The fourth code does nothing.
//   Result channel: out_valid is high for exactly one cycle with out_found_index
//   and out_found; the receiver cannot stall, so the word must be taken then.
//   Every command returns exactly one result word.
//   Busy: a write, the no-op code, or a search that starts at or past the size
//   returns its word in the cycle after acceptance and leaves busy low, so the next
//   command can follow in the next cycle. A search holds busy high while it examines
//   the map from the start byte, one byte per cycle, and returns its word as busy drops;
//   the single read port of the memory sets that rate.
//   Reset: the size register returns to 4096 and the memory is cleared by a pass of
//   one byte per cycle over every byte of the map, with busy high.
//   Configuration writes are taken at any time through the cfg_ port but must only
//   change the size while no command is in flight.
module bitmap_find_next_set_unit
  import bfs_pkg::*;
#(
  parameter int MAX_BITS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [BADDR_W-1:0] in_byte_address,
  input  logic [BYTE_W-1:0]  in_byte_data,
  input  logic [START_W-1:0] in_start_index,
  // result channel
  output logic               out_valid,
  output logic [SIZE_W-1:0]  out_found_index,
  output logic               out_found,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int DEPTH = (MAX_BITS + BYTE_W - 1) / BYTE_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] size_eff;
  logic              cfg_wr;
  result_t           res;
  logic              res_valid;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // APB: zero wait states; bit 2 of the address picks the register slot.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    size_nxt = size_r;
    if (cfg_wr && (cfg_paddr[2] == REG_SIZE)) begin
      size_nxt = cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_SIZE) begin
      cfg_prdata = 32'(size_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(4096);
    end else begin
      size_r <= size_nxt;
    end
  end

  // Clamp the programmed size to the capacity of the map.
  assign size_eff = (32'(size_r) > 32'(MAX_BITS)) ? SIZE_W'(MAX_BITS) : size_r;

  bfs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .func         (in_func),
    .byte_address (in_byte_address),
    .byte_data    (in_byte_data),
    .start_index  (in_start_index),
    .size_eff     (size_eff),
    .busy         (busy),
    .res_valid    (res_valid),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  bfs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid       = res_valid;
  assign out_found_index = res.index;
  assign out_found       = res.found;

endmodule
